@@ design/hlc_pkg.sv @@
// ----------------------------------------------------------------------------
// hlc_pkg
// Types and constants shared by the homogeneous line clipper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hlc_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // ratio t lies in [0, 1], so it needs one integer bit
    localparam int T_BITS    = FRAC_BITS + 1;
    // magnitudes of plane values and their differences
    localparam int UB        = WORD_BITS + 2;
    // coordinate difference between endpoints
    localparam int DW        = WORD_BITS + 1;
    localparam int PROD_BITS = DW + T_BITS;

    localparam logic [WORD_BITS-1:0] EPS = WORD_BITS'(1);

    localparam int STAGE_W     = 0;
    localparam int STAGE_COUNT = 7;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [3:0][WORD_BITS-1:0] point_t;

    typedef struct packed {
        word_t a_x;
        word_t a_y;
        word_t a_z;
        word_t a_w;
        word_t b_x;
        word_t b_y;
        word_t b_z;
        word_t b_w;
    } seg_in_t;

    typedef struct packed {
        logic  rejected;
        word_t out_a_x;
        word_t out_a_y;
        word_t out_a_z;
        word_t out_a_w;
        word_t out_b_x;
        word_t out_b_y;
        word_t out_b_z;
        word_t out_b_w;
    } seg_out_t;

    // segment as it moves through the back end
    typedef struct packed {
        point_t a;
        point_t b;
        logic   rej;
        logic   a_low;
        logic   b_low;
    } seg_t;

    // per-stage work item carried alongside the divider
    typedef struct packed {
        seg_t                   seg;
        logic                   act;
        logic                   sel_a;
        logic                   swap;
        logic [3:0][DW-1:0]     dmag;
        logic [3:0]             dneg;
    } work_t;

endpackage

`default_nettype wire

@@ design/hlc_front.sv @@
// ----------------------------------------------------------------------------
// hlc_front
// Input register: accepts segments and flags endpoints with w below epsilon.
// ----------------------------------------------------------------------------
`default_nettype none

module hlc_front
    import hlc_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     push,
    output logic    full,
    input  seg_in_t item,
    output logic    q_push,
    input  wire     q_full,
    output seg_t    q_data
);

    logic fr_v_reg;
    logic fr_v_next;
    seg_t fr_reg;
    seg_t fr_next;
    logic acc;

    assign full   = fr_v_reg && q_full;
    assign acc    = push && !full;
    assign q_push = fr_v_reg && !q_full;
    assign q_data = fr_reg;

    always_comb
    begin
        fr_next.a     = {item.a_w, item.a_z, item.a_y, item.a_x};
        fr_next.b     = {item.b_w, item.b_z, item.b_y, item.b_x};
        fr_next.rej   = 1'b0;
        fr_next.a_low = item.a_w[WORD_BITS-1] || (item.a_w == '0);
        fr_next.b_low = item.b_w[WORD_BITS-1] || (item.b_w == '0);
    end

    always_comb
    begin
        fr_v_next = fr_v_reg;
        if (acc)
        begin
            fr_v_next = 1'b1;
        end
        else if (q_push)
        begin
            fr_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_v_reg <= 1'b0;
        end
        else
        begin
            fr_v_reg <= fr_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            fr_reg <= fr_next;
        end
    end

endmodule

`default_nettype wire

@@ design/hlc_queue.sv @@
// ----------------------------------------------------------------------------
// hlc_queue
// Four-entry queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hlc_queue
    import hlc_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   wr,
    input  seg_t  wr_data,
    output logic  q_full,
    input  wire   rd,
    output logic  q_empty,
    output seg_t  rd_data
);

    seg_t       mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign q_full  = (cnt_reg == 3'd4);
    assign q_empty = (cnt_reg == 3'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ design/hlc_div.sv @@
// ----------------------------------------------------------------------------
// hlc_div
// Pipelined restoring divider: one quotient bit per stage, t = num*2^F/den.
// ----------------------------------------------------------------------------
`default_nettype none

module hlc_div
    import hlc_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               en,
    input  wire               in_v,
    input  wire  [UB-1:0]     num,
    input  wire  [UB-1:0]     den,
    input  work_t             pay,
    output logic              out_v,
    output logic [T_BITS-1:0] q,
    output work_t             out_pay
);

    logic [UB-1:0]     r_reg   [T_BITS];
    logic [T_BITS-1:0] q_reg   [T_BITS];
    logic [UB-1:0]     den_reg [T_BITS];
    work_t             pay_reg [T_BITS];
    logic [T_BITS-1:0] v_reg;

    for (genvar i = 0; i < T_BITS; i++)
    begin : g_step
        logic [UB-1:0]     r_in;
        logic [UB-1:0]     d_in;
        logic [T_BITS-1:0] q_in;
        logic              v_in;
        work_t             p_in;
        logic [UB:0]       sh;
        logic [UB:0]       diff;
        logic              bit_q;

        if (i == 0)
        begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
            assign v_in = in_v;
            assign p_in = pay;
            // integer bit: the ratio never exceeds one, so no shift here
            assign sh   = {1'b0, r_in};
        end
        else
        begin : g_next
            assign r_in = r_reg[i-1];
            assign d_in = den_reg[i-1];
            assign q_in = q_reg[i-1];
            assign v_in = v_reg[i-1];
            assign p_in = pay_reg[i-1];
            assign sh   = {r_in, 1'b0};
        end

        assign diff  = sh - {1'b0, d_in};
        assign bit_q = !diff[UB];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i]   <= bit_q ? diff[UB-1:0] : sh[UB-1:0];
                q_reg[i]   <= {q_in[T_BITS-2:0], bit_q};
                den_reg[i] <= d_in;
                pay_reg[i] <= p_in;
            end
        end
    end

    assign out_v   = v_reg[T_BITS-1];
    assign q       = q_reg[T_BITS-1];
    assign out_pay = pay_reg[T_BITS-1];

endmodule

`default_nettype wire

@@ design/hlc_clip.sv @@
// ----------------------------------------------------------------------------
// hlc_clip
// One clip step: the w-epsilon pull or one view-volume plane, with divider,
// multiplier and saturating add stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hlc_clip
    import hlc_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   en,
    input  wire   in_v,
    input  seg_t  in_seg,
    output logic  out_v,
    output seg_t  out_seg
);

    localparam int AX  = (STAGE == STAGE_W) ? 0 : (STAGE - 1) % 3;
    localparam bit NEG = (STAGE > 3);
    localparam int PW  = PROD_BITS - FRAC_BITS;
    localparam int SW  = PW + 2;

    // ---------------- classify and set up the ratio ----------------
    work_t                w0;
    logic [UB-1:0]        num0;
    logic [UB-1:0]        den0;
    point_t               base0;
    point_t               other0;
    logic signed [UB-1:0] d1;
    logic signed [UB-1:0] d2;
    logic signed [UB:0]   dd;
    logic signed [DW-1:0] df [4];

    always_comb
    begin
        w0.seg   = in_seg;
        w0.act   = 1'b0;
        w0.sel_a = 1'b0;
        w0.swap  = 1'b0;
        num0     = '0;
        den0     = '0;
        d1       = '0;
        d2       = '0;
        dd       = '0;
        if (STAGE == STAGE_W)
        begin
            w0.swap = in_seg.a_low;
        end
        base0  = w0.swap ? in_seg.b : in_seg.a;
        other0 = w0.swap ? in_seg.a : in_seg.b;
        for (int k = 0; k < 4; k++)
        begin
            df[k] = $signed({other0[k][WORD_BITS-1], other0[k]})
                  - $signed({base0[k][WORD_BITS-1], base0[k]});
            w0.dneg[k] = df[k][DW-1];
            w0.dmag[k] = df[k][DW-1] ? DW'(-df[k]) : DW'(df[k]);
        end
        if (STAGE == STAGE_W)
        begin
            num0 = UB'($signed(base0[3])) - UB'(1);
            den0 = UB'($signed(base0[3])) - UB'($signed(other0[3]));
            if (!in_seg.rej)
            begin
                if (in_seg.a_low && in_seg.b_low)
                begin
                    w0.seg.rej = 1'b1;
                end
                else if (in_seg.a_low || in_seg.b_low)
                begin
                    w0.act   = 1'b1;
                    w0.sel_a = in_seg.a_low;
                end
            end
        end
        else
        begin
            if (NEG)
            begin
                d1 = UB'($signed(in_seg.a[3])) - UB'($signed(in_seg.a[AX]));
                d2 = UB'($signed(in_seg.b[3])) - UB'($signed(in_seg.b[AX]));
            end
            else
            begin
                d1 = UB'($signed(in_seg.a[3])) + UB'($signed(in_seg.a[AX]));
                d2 = UB'($signed(in_seg.b[3])) + UB'($signed(in_seg.b[AX]));
            end
            dd   = (UB+1)'(d1) - (UB+1)'(d2);
            num0 = d1[UB-1] ? UB'(-d1) : UB'(d1);
            den0 = dd[UB] ? UB'(-dd) : UB'(dd);
            if (!in_seg.rej)
            begin
                if (d1[UB-1] && d2[UB-1])
                begin
                    w0.seg.rej = 1'b1;
                end
                else if (d1[UB-1] || d2[UB-1])
                begin
                    w0.act   = 1'b1;
                    w0.sel_a = d1[UB-1];
                end
            end
        end
    end

    logic          v0_reg;
    work_t         w0_reg;
    logic [UB-1:0] num_reg;
    logic [UB-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w0_reg  <= w0;
            num_reg <= num0;
            den_reg <= den0;
        end
    end

    // ---------------- ratio ----------------
    logic              vd;
    logic [T_BITS-1:0] qd;
    work_t             wd;

    hlc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_v    (v0_reg),
        .num     (num_reg),
        .den     (den_reg),
        .pay     (w0_reg),
        .out_v   (vd),
        .q       (qd),
        .out_pay (wd)
    );

    // ---------------- scale differences by t ----------------
    logic                 v1_reg;
    work_t                w1_reg;
    logic [PROD_BITS-1:0] prod_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_reg <= wd;
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PROD_BITS'(wd.dmag[k]) * PROD_BITS'(qd);
            end
        end
    end

    // ---------------- add to base, saturate, replace endpoint ----------------
    point_t               base2;
    point_t               np;
    logic [PW-1:0]        pm   [4];
    logic signed [PW:0]   off  [4];
    logic signed [SW-1:0] sum  [4];
    seg_t                 s2;

    always_comb
    begin
        base2 = w1_reg.swap ? w1_reg.seg.b : w1_reg.seg.a;
        for (int k = 0; k < 4; k++)
        begin
            pm[k]  = prod_reg[k][PROD_BITS-1:FRAC_BITS];
            off[k] = w1_reg.dneg[k] ? -$signed({1'b0, pm[k]}) : $signed({1'b0, pm[k]});
            sum[k] = SW'($signed(base2[k])) + SW'(off[k]);
            if (sum[k][SW-1:WORD_BITS-1] == '0 || sum[k][SW-1:WORD_BITS-1] == '1)
            begin
                np[k] = sum[k][WORD_BITS-1:0];
            end
            else if (sum[k][SW-1])
            begin
                np[k] = {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            else
            begin
                np[k] = {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end
        if (STAGE == STAGE_W)
        begin
            np[3] = EPS;
        end
        s2 = w1_reg.seg;
        if (w1_reg.act)
        begin
            if (w1_reg.sel_a)
            begin
                s2.a = np;
            end
            else
            begin
                s2.b = np;
            end
        end
    end

    logic v2_reg;
    seg_t s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2;
        end
    end

    assign out_v   = v2_reg;
    assign out_seg = s2_reg;

endmodule

`default_nettype wire

@@ design/homogeneous_line_clipper.sv @@
// ----------------------------------------------------------------------------
// homogeneous_line_clipper
// Clips a homogeneous line segment to the canonical view volume.
// ----------------------------------------------------------------------------
// Throughput: one segment per cycle, sustained while results are popped; a held result stalls the back end.
// A segment passes the input register, the four-entry queue and seven clip steps,
// each with a one-bit-per-stage divider.
// The back end advances as a whole while its last stage is free or popped.
// Reset: rst_n clears all valid state asynchronously; the block comes up empty.
`default_nettype none

module homogeneous_line_clipper
    import hlc_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      push,
    output logic     full,
    input  seg_in_t  item,
    output logic     empty,
    input  wire      pop,
    output seg_out_t result
);

    logic q_push;
    logic q_full;
    logic q_empty;
    logic q_rd;
    seg_t q_wdata;
    seg_t q_rdata;
    logic adv;

    hlc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    hlc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rd_data (q_rdata)
    );

    logic [STAGE_COUNT:0] v;
    seg_t                 s [STAGE_COUNT+1];

    assign v[0] = !q_empty;
    assign s[0] = q_rdata;
    assign adv  = !v[STAGE_COUNT] || pop;
    assign q_rd = adv && !q_empty;

    for (genvar i = 0; i < STAGE_COUNT; i++)
    begin : g_clip
        hlc_clip #(.STAGE(i)) u_clip (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_v    (v[i]),
            .in_seg  (s[i]),
            .out_v   (v[i+1]),
            .out_seg (s[i+1])
        );
    end

    seg_t fin;
    assign fin   = s[STAGE_COUNT];
    assign empty = !v[STAGE_COUNT];

    always_comb
    begin
        result.rejected = fin.rej;
        if (fin.rej)
        begin
            result.out_a_x = '0;
            result.out_a_y = '0;
            result.out_a_z = '0;
            result.out_a_w = '0;
            result.out_b_x = '0;
            result.out_b_y = '0;
            result.out_b_z = '0;
            result.out_b_w = '0;
        end
        else
        begin
            result.out_a_x = fin.a[0];
            result.out_a_y = fin.a[1];
            result.out_a_z = fin.a[2];
            result.out_a_w = fin.a[3];
            result.out_b_x = fin.b[0];
            result.out_b_y = fin.b[1];
            result.out_b_z = fin.b[2];
            result.out_b_w = fin.b[3];
        end
    end

endmodule

`default_nettype wire
